@@ sv/aes128_key_expansion_defines.svh @@
// Assertion macros used by the checker file of the AES-128 key schedule.
// No dependencies.
`ifndef AES128_KEY_EXPANSION_DEFINES_SVH
`define AES128_KEY_EXPANSION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AKX_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define AKX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ sv/aes_kx_pkg.sv @@
// Shared constants and tables for the AES-128 key schedule: S-box, round
// constants, widths. No dependencies.
package aes_kx_pkg;

  localparam int unsigned KeyW   = 128;
  localparam int unsigned WordW  = 32;
  localparam int unsigned RoundW = 4;

  localparam logic [RoundW-1:0] LAST_ROUND = 4'd10;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constant used to build round key r+1 from round key r.
  function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
    logic [7:0] c;
    unique case (r)
      4'd0:    c = 8'h01;
      4'd1:    c = 8'h02;
      4'd2:    c = 8'h04;
      4'd3:    c = 8'h08;
      4'd4:    c = 8'h10;
      4'd5:    c = 8'h20;
      4'd6:    c = 8'h40;
      4'd7:    c = 8'h80;
      4'd8:    c = 8'h1b;
      4'd9:    c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ sv/aes128_key_expansion.sv @@
// AES-128 key schedule. Each accepted key yields 11 round keys, rounds 0 to
// 10, one per cycle while round_ready is high; round 10 carries last_round.
// A single round unit steps the key register once per cycle while the
// output register can advance. The next key is taken in the cycle round 10
// moves to the output register, so keys stream with no gap; a result held
// by a stalled consumer does not block the round unit from holding the next.
// Depends on aes_kx_pkg and aes_kx_round.
module aes128_key_expansion import aes_kx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_valid,
  output logic              key_ready,
  input  logic [63:0]       key_high,
  input  logic [63:0]       key_low,
  output logic              round_valid,
  input  logic              round_ready,
  output logic [RoundW-1:0] round_number,
  output logic [63:0]       round_key_high,
  output logic [63:0]       round_key_low,
  output logic              last_round
);

  // generator register: round key waiting to move to the output
  logic              gen_valid;
  logic [KeyW-1:0]   gen_key;
  logic [RoundW-1:0] gen_round;
  logic [KeyW-1:0]   gen_key_next;

  logic advance, gen_last, key_take;

  aes_kx_round u_round (
    .cur_key   (gen_key),
    .cur_round (gen_round),
    .next_key  (gen_key_next)
  );

  assign advance   = gen_valid && (!round_valid || round_ready);
  assign gen_last  = (gen_round == LAST_ROUND);
  assign key_ready = !gen_valid || (advance && gen_last);
  assign key_take  = key_valid && key_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_valid   <= 1'b0;
      round_valid <= 1'b0;
    end else begin
      if (key_take) begin
        gen_valid <= 1'b1;
      end else if (advance && gen_last) begin
        gen_valid <= 1'b0;
      end
      if (advance) begin
        round_valid <= 1'b1;
      end else if (round_ready) begin
        round_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_take) begin
      gen_key   <= {key_high, key_low};
      gen_round <= '0;
    end else if (advance && !gen_last) begin
      gen_key   <= gen_key_next;
      gen_round <= gen_round + 4'd1;
    end
    if (advance) begin
      round_number   <= gen_round;
      round_key_high <= gen_key[127:64];
      round_key_low  <= gen_key[63:0];
      last_round     <= gen_last;
    end
  end

endmodule

@@ sv/aes_kx_round.sv @@
// One AES-128 key schedule round: round key r to round key r+1.
// Depends on aes_kx_pkg (S-box, round constants).
module aes_kx_round import aes_kx_pkg::*; (
  input  logic [KeyW-1:0]   cur_key,
  input  logic [RoundW-1:0] cur_round,
  output logic [KeyW-1:0]   next_key
);

  logic [WordW-1:0] w0, w1, w2, w3;
  logic [WordW-1:0] rot, sub, t;
  logic [WordW-1:0] n0, n1, n2, n3;

  always_comb begin
    w0  = cur_key[127:96];
    w1  = cur_key[95:64];
    w2  = cur_key[63:32];
    w3  = cur_key[31:0];
    rot = {w3[23:0], w3[31:24]};
    sub = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
    t   = sub ^ {rcon(cur_round), 24'h000000};
    n0  = w0 ^ t;
    n1  = w1 ^ n0;
    n2  = w2 ^ n1;
    n3  = w3 ^ n2;
    next_key = {n0, n1, n2, n3};
  end

endmodule

@@ sv/aes_kx_checker.sv @@
// Port-level checks for the AES-128 key schedule, bound to the top level.
// Depends on aes_kx_pkg and aes128_key_expansion_defines.svh.
`include "aes128_key_expansion_defines.svh"

module aes_kx_checker import aes_kx_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              round_valid,
  input logic              round_ready,
  input logic [RoundW-1:0] round_number,
  input logic [63:0]       round_key_high,
  input logic [63:0]       round_key_low,
  input logic              last_round
);

  logic out_take;
  assign out_take = round_valid && round_ready;

  // a stalled result holds
  `AKX_ASSERT_NEXT(a_hold, clk, rst, round_valid && !round_ready,
    round_valid && $stable(round_key_high) && $stable(round_key_low) &&
    $stable(round_number))

  // within a run, rounds follow with no gap
  `AKX_ASSERT_NEXT(a_step, clk, rst, out_take && !last_round,
    round_valid && round_number == 4'($past(round_number) + 4'd1))

  `AKX_ASSERT_NOW(a_last, clk, rst, round_valid, last_round == (round_number == LAST_ROUND))

  // a finished run is followed by round 0 of the next key
  `AKX_ASSERT_NEXT(a_restart, clk, rst, out_take && last_round,
    !round_valid || round_number == 4'd0)

endmodule

bind aes128_key_expansion aes_kx_checker u_aes_kx_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for aes128_key_expansion: each key request is
// expanded by an independent schedule model and all 11 round keys are checked.
// Depends on aes_kx_pkg and the aes128_key_expansion RTL.
module testbench;
  import aes_kx_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_KEYS  = 343;
  localparam int DIRECTED_CNT = 17;

  typedef struct packed {
    logic [63:0]       key_hi;
    logic [63:0]       key_lo;
    logic              has_known;
    logic [RoundW-1:0] known_round;
    logic [63:0]       known_hi;
    logic [63:0]       known_lo;
  } directed_row_t;

  typedef struct {
    logic [RoundW-1:0] rnd;
    logic [63:0]       hi;
    logic [63:0]       lo;
    logic              last;
  } round_key_t;

  // Known values are standard published schedule words.
  localparam directed_row_t DIRECTED_KEYS [DIRECTED_CNT] = '{
    '{64'h0, 64'h0, 1'b1, 4'd1, 64'h6263636362636363, 64'h6263636362636363},
    '{64'hffffffffffffffff, 64'hffffffffffffffff,
      1'b1, 4'd0, 64'hffffffffffffffff, 64'hffffffffffffffff},
    '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
      1'b1, 4'd10, 64'hd014f9a8c9ee2589, 64'he13f0cc8b6630ca6},
    '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
      1'b1, 4'd1, 64'ha0fafe1788542cb1, 64'h23a339392a6c7605},
    '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
      1'b1, 4'd10, 64'h13111d7fe3944a17, 64'hf307a78b4d2b30c5},
    '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 4'd0, 64'h0, 64'h0},
    '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 4'd0, 64'h0, 64'h0},
    '{64'h8000000000000000, 64'h0, 1'b0, 4'd0, 64'h0, 64'h0},
    '{64'h0, 64'h1, 1'b0, 4'd0, 64'h0, 64'h0},
    '{64'h1, 64'h0, 1'b0, 4'd0, 64'h0, 64'h0},
    '{64'h0, 64'h8000000000000000, 1'b0, 4'd0, 64'h0, 64'h0},
    '{64'h0, 64'h00000000ffffffff, 1'b0, 4'd0, 64'h0, 64'h0},
    '{64'h0, 64'h00000000ff000000, 1'b0, 4'd0, 64'h0, 64'h0},
    '{64'h0, 64'h0000000000000080, 1'b0, 4'd0, 64'h0, 64'h0},
    '{64'hffffffffffffffff, 64'h0, 1'b0, 4'd0, 64'h0, 64'h0},
    '{64'h0, 64'hffffffffffffffff, 1'b0, 4'd0, 64'h0, 64'h0},
    '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 4'd0, 64'h0, 64'h0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              key_valid = 1'b0;
  logic              key_ready;
  logic [63:0]       key_high = '0;
  logic [63:0]       key_low = '0;
  logic              round_valid;
  logic              round_ready = 1'b0;
  logic [RoundW-1:0] round_number;
  logic [63:0]       round_key_high;
  logic [63:0]       round_key_low;
  logic              last_round;

  logic [7:0]  sbox_table [256];
  round_key_t  pending_round_keys [$];
  round_key_t  want;
  int          error_count = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          cycle_count = 0;

  aes128_key_expansion i_dut (
    .clk           (clk),
    .rst           (rst),
    .key_valid     (key_valid),
    .key_ready     (key_ready),
    .key_high      (key_high),
    .key_low       (key_low),
    .round_valid   (round_valid),
    .round_ready   (round_ready),
    .round_number  (round_number),
    .round_key_high(round_key_high),
    .round_key_low (round_key_low),
    .last_round    (last_round)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    int         i;
    p = 8'h00;
    x = a;
    for (i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    return p;
  endfunction

  // One schedule step: rotate, substitute and add the round constant to the
  // last word, then chain the XOR through all four words.
  function automatic logic [127:0] next_round_key(logic [127:0] rk, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    t  = {w3[23:0], w3[31:24]};
    t  = {sbox_table[t[31:24]] ^ rc, sbox_table[t[23:16]],
          sbox_table[t[15:8]], sbox_table[t[7:0]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // Offers one key request; on acceptance queues its 11 round keys.
  task automatic offer_key(input logic [63:0] hi, input logic [63:0] lo,
                           input logic has_known, input logic [RoundW-1:0] known_round,
                           input logic [63:0] known_hi, input logic [63:0] known_lo,
                           input bit steady);
    logic [127:0] rk;
    logic [7:0]   rc;
    round_key_t   item;
    int           r;
    while (!steady && $urandom_range(99) < 35) begin
      key_valid <= 1'b0;
      @(posedge clk);
    end
    key_valid <= 1'b1;
    key_high  <= hi;
    key_low   <= lo;
    @(posedge clk);
    while (!key_ready) @(posedge clk);
    rk = {hi, lo};
    rc = 8'h01;
    for (r = 0; r <= 10; r++) begin
      item.rnd  = RoundW'(r);
      item.hi   = rk[127:64];
      item.lo   = rk[63:0];
      item.last = (RoundW'(r) == LAST_ROUND);
      if (has_known && known_round == RoundW'(r)) begin
        item.hi = known_hi;
        item.lo = known_lo;
      end
      pending_round_keys.push_back(item);
      rk = next_round_key(rk, rc);
      rc = xtime(rc);
    end
  endtask

  // Result side: check, then pick next ready. One long hold lets the block
  // back up into the key request side.
  always @(posedge clk) begin
    if (!rst && round_valid && round_ready) begin
      results_seen++;
      if (pending_round_keys.size() == 0) begin
        if (error_count < 10)
          $display("unexpected round key: round %0d %h_%h last %b",
                   round_number, round_key_high, round_key_low, last_round);
        error_count++;
      end else begin
        want = pending_round_keys.pop_front();
        if (want.rnd !== round_number || want.hi !== round_key_high ||
            want.lo !== round_key_low || want.last !== last_round) begin
          if (error_count < 10)
            $display("round key mismatch: expected round %0d %h_%h last %b, got round %0d %h_%h last %b",
                     want.rnd, want.hi, want.lo, want.last,
                     round_number, round_key_high, round_key_low, last_round);
          error_count++;
        end
      end
    end
    if (hold_left > 0) begin
      round_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= 330) begin
      hold_done = 1'b1;
      hold_left = 300;
      round_ready <= 1'b0;
    end else if (results_seen >= 1650 && results_seen < 2300) begin
      round_ready <= 1'b1;
    end else begin
      round_ready <= ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("aes128_key_expansion: mismatch");
      $finish;
    end
  end

  initial begin
    int           a, b, n, j, mode;
    logic [7:0]   inv;
    logic [127:0] kw;

    // S-box from the field inverse and the affine map
    for (a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (b = 1; b < 256; b++)
        if (gf_mul(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
      sbox_table[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                      {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < DIRECTED_CNT; n++)
      offer_key(DIRECTED_KEYS[n].key_hi, DIRECTED_KEYS[n].key_lo,
                DIRECTED_KEYS[n].has_known, DIRECTED_KEYS[n].known_round,
                DIRECTED_KEYS[n].known_hi, DIRECTED_KEYS[n].known_lo, 1'b0);

    for (n = 0; n < RANDOM_KEYS; n++) begin
      if (n == 100) begin
        // let the pipeline drain completely before the next request
        key_valid <= 1'b0;
        while (pending_round_keys.size() != 0) @(posedge clk);
      end
      mode = $urandom_range(99);
      if (mode < 70) begin
        kw = {$urandom, $urandom, $urandom, $urandom};
      end else if (mode < 85) begin
        for (j = 0; j < 16; j++) begin
          case ($urandom_range(2))
            0:       kw[j*8 +: 8] = 8'h00;
            1:       kw[j*8 +: 8] = 8'hff;
            default: kw[j*8 +: 8] = 8'($urandom);
          endcase
        end
      end else begin
        kw = 128'd1 << $urandom_range(127);
        if ($urandom_range(1) == 1) kw = ~kw;
      end
      offer_key(kw[127:64], kw[63:0], 1'b0, 4'd0, 64'h0, 64'h0,
                n >= 150 && n < 210);
    end
    key_valid <= 1'b0;

    while (pending_round_keys.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("aes128_key_expansion: match");
    end else begin
      $display("aes128_key_expansion: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/aes_kx_pkg.sv
sv/aes_kx_round.sv
sv/aes128_key_expansion.sv
sv/aes_kx_checker.sv
sim/testbench.sv
